[rtl/core/wlc_pkg.sv]
// Shared types and constants for the window lifter controller.
// No dependencies; every other file in the block imports this package.
package wlc_pkg;

	localparam int WLC_NUM_STEPS = 10;
	localparam int WLC_CFG_IDX_W = 4;
	localparam int WLC_CFG_DATA_W = 16;
	localparam int WLC_BAR_W = 10;
	localparam int WLC_LEVEL_W = 4;
	localparam int WLC_TICK_W = 16;
	localparam int WLC_DEB_W = 10;

	localparam logic [WLC_CFG_IDX_W-1:0] REG_DEBOUNCE   = 4'd0;
	localparam logic [WLC_CFG_IDX_W-1:0] REG_ONESHOT    = 4'd1;
	localparam logic [WLC_CFG_IDX_W-1:0] REG_STEP       = 4'd2;
	localparam logic [WLC_CFG_IDX_W-1:0] REG_PINCH_HOLD = 4'd3;

	localparam logic [WLC_DEB_W-1:0]  DEBOUNCE_RST   = 10'd10;
	localparam logic [WLC_TICK_W-1:0] ONESHOT_RST    = 16'd500;
	localparam logic [WLC_TICK_W-1:0] STEP_RST       = 16'd400;
	localparam logic [WLC_TICK_W-1:0] PINCH_HOLD_RST = 16'd5000;

	typedef struct packed {
		logic [WLC_DEB_W-1:0]  debounce_ticks;
		logic [WLC_TICK_W-1:0] oneshot_ticks;
		logic [WLC_TICK_W-1:0] step_ticks;
		logic [WLC_TICK_W-1:0] pinch_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic [WLC_BAR_W-1:0]   bar_leds;
		logic [WLC_LEVEL_W-1:0] window_level;
		logic                   motor_up;
		logic                   motor_down;
		logic                   pinch_lockout;
	} res_t;

endpackage

[rtl/core/wlc_if.sv]
// Handshake channels of the window lifter controller: tick input, result
// output and configuration write. Depends on wlc_pkg.
interface wlc_tick_if;
	logic valid;
	logic ready;
	logic up_button;
	logic down_button;
	logic pinch_sensor;
	modport source (output valid, up_button, down_button, pinch_sensor, input ready);
	modport sink (input valid, up_button, down_button, pinch_sensor, output ready);
endinterface

interface wlc_res_if;
	import wlc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [WLC_BAR_W-1:0]   bar_leds;
	logic [WLC_LEVEL_W-1:0] window_level;
	logic                   motor_up;
	logic                   motor_down;
	logic                   pinch_lockout;
	modport source (output valid, bar_leds, window_level, motor_up, motor_down,
		pinch_lockout, input ready);
	modport sink (input valid, bar_leds, window_level, motor_up, motor_down,
		pinch_lockout, output ready);
endinterface

interface wlc_cfg_if;
	import wlc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [WLC_CFG_IDX_W-1:0]  index;
	logic [WLC_CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/wlc_fsm.sv]
// Window control state machine: debounce, one-touch decision, stepping and
// pinch reopening. Computes the next result from each tick. Depends on wlc_pkg.
module wlc_fsm #(
	parameter int NUM_STEPS = wlc_pkg::WLC_NUM_STEPS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          up_button,
	input  logic          down_button,
	input  logic          pinch_sensor,
	input  wlc_pkg::cfg_t cfg,
	output wlc_pkg::res_t nxt
);
	import wlc_pkg::*;

	localparam int OW = $clog2(NUM_STEPS + 1);
	localparam logic [OW-1:0] NS = OW'(NUM_STEPS);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DEBOUNCE,
		PH_ONESHOT,
		PH_MANUAL,
		PH_AUTO,
		PH_PINCH_OPEN,
		PH_PINCH_HOLD
	} phase_t;

	phase_t                phase_q, phase_n;
	logic                  down_q, down_n;
	logic [WLC_TICK_W-1:0] tick_q, tick_n, tick_inc;
	logic [OW-1:0]         open_q, open_n, open_fwd, open_bwd, open_mv;
	logic                  held, end_now, end_mv;
	logic [WLC_TICK_W-1:0] deb_ext;
	logic [31:0]           lvl_ext;

	always_comb begin
		phase_n  = phase_q;
		down_n   = down_q;
		tick_n   = tick_q;
		open_n   = open_q;
		held     = down_q ? down_button : up_button;
		tick_inc = (tick_q == '1) ? tick_q : tick_q + 16'd1;
		deb_ext  = {{(WLC_TICK_W-WLC_DEB_W){1'b0}}, cfg.debounce_ticks};
		open_fwd = (open_q < NS) ? open_q + OW'(1) : open_q;
		open_bwd = (open_q != '0) ? open_q - OW'(1) : open_q;
		open_mv  = down_q ? open_fwd : open_bwd;
		end_now  = down_q ? (open_q >= NS) : (open_q == '0);
		end_mv   = down_q ? (open_mv >= NS) : (open_mv == '0);
		case (phase_q)
			PH_IDLE: begin
				if (down_button || up_button) begin
					down_n  = down_button;
					phase_n = PH_DEBOUNCE;
					tick_n  = 16'd1;
					if (16'd1 >= deb_ext) begin
						phase_n = PH_ONESHOT;
						tick_n  = '0;
					end
				end
			end
			PH_DEBOUNCE: begin
				if (!held) begin
					phase_n = PH_IDLE;
					tick_n  = '0;
				end else begin
					tick_n = tick_inc;
					if (tick_inc >= deb_ext) begin
						phase_n = PH_ONESHOT;
						tick_n  = '0;
					end
				end
			end
			PH_ONESHOT: begin
				tick_n = tick_inc;
				if (tick_inc >= cfg.oneshot_ticks) begin
					tick_n = '0;
					if (end_now) begin
						phase_n = PH_IDLE;
					end else begin
						open_n = open_mv;
						if (end_mv) begin
							phase_n = PH_IDLE;
						end else begin
							phase_n = held ? PH_MANUAL : PH_AUTO;
						end
					end
				end
			end
			PH_MANUAL, PH_AUTO: begin
				if (!down_q && pinch_sensor) begin
					down_n  = 1'b1;
					tick_n  = '0;
					open_n  = open_fwd;
					phase_n = (open_fwd >= NS) ? PH_PINCH_HOLD : PH_PINCH_OPEN;
				end else if (phase_q == PH_MANUAL && !held) begin
					phase_n = PH_IDLE;
					tick_n  = '0;
				end else begin
					tick_n = tick_inc;
					if (tick_inc >= cfg.step_ticks) begin
						tick_n = '0;
						open_n = open_mv;
						if (end_mv) begin
							phase_n = PH_IDLE;
						end
					end
				end
			end
			PH_PINCH_OPEN: begin
				tick_n = tick_inc;
				if (tick_inc >= cfg.step_ticks) begin
					tick_n = '0;
					open_n = open_fwd;
					if (open_fwd >= NS) begin
						phase_n = PH_PINCH_HOLD;
					end
				end
			end
			PH_PINCH_HOLD: begin
				tick_n = tick_inc;
				if (tick_inc >= cfg.pinch_hold_ticks) begin
					phase_n = PH_IDLE;
					tick_n  = '0;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				tick_n  = '0;
			end
		endcase
	end

	always_comb begin
		lvl_ext = 32'(open_n);
		for (int i = 0; i < WLC_BAR_W; i++) begin
			nxt.bar_leds[i] = (i < NUM_STEPS) && (i >= int'(lvl_ext));
		end
		nxt.window_level  = lvl_ext[WLC_LEVEL_W-1:0];
		nxt.motor_up      = (phase_n == PH_MANUAL || phase_n == PH_AUTO) && !down_n;
		nxt.motor_down    = ((phase_n == PH_MANUAL || phase_n == PH_AUTO) && down_n)
			|| phase_n == PH_PINCH_OPEN;
		nxt.pinch_lockout = phase_n == PH_PINCH_OPEN || phase_n == PH_PINCH_HOLD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			down_q  <= 1'b0;
			tick_q  <= '0;
			open_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			down_q  <= down_n;
			tick_q  <= tick_n;
			open_q  <= open_n;
		end
	end

endmodule

[rtl/core/window_lifter_controller.sv]
// Power window controller with one-touch travel and anti-pinch protection.
// Depends on wlc_pkg, the channel interfaces in wlc_if.sv and wlc_fsm.
//
// Usage: send one transaction on the tick channel per millisecond tick,
// carrying the up button, down button and pinch sensor. Each tick yields
// exactly one result transaction with the position bar, window level, motor
// drives and pinch lockout flag, all reflecting the state after that tick.
// The result is registered: the result of a tick accepted at one edge is valid
// right after that edge. Throughput is one tick per cycle while the receiver
// keeps ready high. The state update is a single pass through the state
// machine between the state registers and the result register, so a new
// tick is taken in the same cycle that the previous result is taken.
// When the receiver stalls, the result is held and the tick channel drops
// ready until the result register frees up; no result is lost.
// The configuration channel is always ready and should be written only while
// no tick is in flight. Reset returns the registers to their defaults, the
// state machine to idle with the window fully closed, and empties the result
// register.
module window_lifter_controller #(
	parameter int NUM_STEPS = wlc_pkg::WLC_NUM_STEPS
) (
	input logic      clk,
	input logic      arst_n,
	wlc_tick_if.sink tick,
	wlc_res_if.source result,
	wlc_cfg_if.sink  cfg
);
	import wlc_pkg::*;

	cfg_t cfg_q;
	res_t res_nxt;
	res_t res_q;
	logic res_valid_q;
	logic take;

	assign tick.ready = !res_valid_q || result.ready;
	assign take       = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.oneshot_ticks    <= ONESHOT_RST;
			cfg_q.step_ticks       <= STEP_RST;
			cfg_q.pinch_hold_ticks <= PINCH_HOLD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg.data[WLC_DEB_W-1:0];
				REG_ONESHOT:    cfg_q.oneshot_ticks    <= cfg.data;
				REG_STEP:       cfg_q.step_ticks       <= cfg.data;
				REG_PINCH_HOLD: cfg_q.pinch_hold_ticks <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	wlc_fsm #(
		.NUM_STEPS(NUM_STEPS)
	) u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (take),
		.up_button    (tick.up_button),
		.down_button  (tick.down_button),
		.pinch_sensor (tick.pinch_sensor),
		.cfg          (cfg_q),
		.nxt          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.bar_leds      = res_q.bar_leds;
	assign result.window_level  = res_q.window_level;
	assign result.motor_up      = res_q.motor_up;
	assign result.motor_down    = res_q.motor_down;
	assign result.pinch_lockout = res_q.pinch_lockout;

endmodule

[verif/window_lifter_controller_tb.sv]
// Self-checking testbench for window_lifter_controller: random and directed button
// and pinch ticks, checked against an in-bench model of the window state machine.
// Depends on wlc_pkg, the channel interfaces in wlc_if.sv and the controller RTL.
module window_lifter_controller_tb;
	import wlc_pkg::*;

	localparam int NUM_STEPS = WLC_NUM_STEPS;
	localparam int LONG_HOLD = 300;
	localparam logic [WLC_CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

	// Each entry is {up_button, down_button, pinch_sensor}.
	localparam logic [2:0] OPENING_SCRIPT [27] = '{
		3'b111, 3'b000, 3'b000, 3'b100, 3'b000, 3'b000, 3'b000, 3'b000, 3'b000,
		3'b000, 3'b000, 3'b000, 3'b010, 3'b010, 3'b010, 3'b100, 3'b100, 3'b100,
		3'b100, 3'b001, 3'b110, 3'b010, 3'b000, 3'b100, 3'b000, 3'b000, 3'b001
	};

	typedef enum logic [2:0] {
		ST_IDLE, ST_DEBOUNCE, ST_ONESHOT, ST_MANUAL, ST_AUTO, ST_PINCH_OPEN, ST_PINCH_HOLD
	} lift_state_t;

	typedef struct packed {
		logic up;
		logic dn;
		logic pin;
	} button_tick_t;

	typedef struct packed {
		logic [WLC_CFG_IDX_W-1:0]  idx;
		logic [WLC_CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk;
	logic arst_n;

	wlc_tick_if tick_ch ();
	wlc_res_if  res_ch ();
	wlc_cfg_if  cfg_ch ();

	window_lifter_controller DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	button_tick_t tick_q[$];
	reg_write_t   reg_write_q[$];
	res_t         window_q[$];

	button_tick_t next_tick;
	reg_write_t   next_write;
	res_t         want;

	int src_idle_pct;
	int sink_idle_pct;
	int src_gap;
	int sink_gap;
	int holds_req;
	int holds_done;
	int hold_left;
	int mismatches;
	int ticks_queued;
	int g_deb;
	int g_os;
	int g_step;
	int g_hold;

	// Model of the controller, updated on every accepted tick and configuration write.
	lift_state_t          wl_state   = ST_IDLE;
	logic                 going_down = 1'b0;
	logic [WLC_TICK_W-1:0] dwell     = '0;
	logic [3:0]           opening    = '0;
	logic [WLC_DEB_W-1:0]  deb_lim   = DEBOUNCE_RST;
	logic [WLC_TICK_W-1:0] os_lim    = ONESHOT_RST;
	logic [WLC_TICK_W-1:0] step_lim  = STEP_RST;
	logic [WLC_TICK_W-1:0] hold_lim  = PINCH_HOLD_RST;

	function automatic void rest_idle();
		wl_state = ST_IDLE;
		dwell = '0;
	endfunction

	function automatic void bump_dwell();
		if (dwell != 16'hFFFF)
			dwell = dwell + 16'd1;
	endfunction

	function automatic void debounce_check();
		if (dwell >= {6'd0, deb_lim}) begin
			wl_state = ST_ONESHOT;
			dwell = '0;
		end
	endfunction

	function automatic logic window_at_end();
		return going_down ? (opening >= NUM_STEPS) : (opening == 0);
	endfunction

	function automatic void step_window();
		if (going_down) begin
			if (opening < NUM_STEPS)
				opening = opening + 4'd1;
		end else if (opening != 0) begin
			opening = opening - 4'd1;
		end
	endfunction

	function automatic void reopen_step();
		if (opening < NUM_STEPS)
			opening = opening + 4'd1;
		if (opening >= NUM_STEPS) begin
			wl_state = ST_PINCH_HOLD;
			dwell = '0;
		end
	endfunction

	function automatic res_t predict_window(logic up, logic dn, logic pin);
		res_t r;
		logic held;
		logic [3:0] lvl;
		logic [10:0] open_mask;
		held = going_down ? dn : up;
		case (wl_state)
			ST_IDLE: if (up || dn) begin
				going_down = dn;
				wl_state = ST_DEBOUNCE;
				dwell = 16'd1;
				debounce_check();
			end
			ST_DEBOUNCE: if (!held) begin
				rest_idle();
			end else begin
				bump_dwell();
				debounce_check();
			end
			ST_ONESHOT: begin
				bump_dwell();
				if (dwell >= os_lim) begin
					if (window_at_end()) begin
						rest_idle();
					end else begin
						step_window();
						if (window_at_end()) begin
							rest_idle();
						end else begin
							wl_state = held ? ST_MANUAL : ST_AUTO;
							dwell = '0;
						end
					end
				end
			end
			ST_MANUAL, ST_AUTO: if (!going_down && pin) begin
				going_down = 1'b1;
				wl_state = ST_PINCH_OPEN;
				dwell = '0;
				reopen_step();
			end else if (wl_state == ST_MANUAL && !held) begin
				rest_idle();
			end else begin
				bump_dwell();
				if (dwell >= step_lim) begin
					dwell = '0;
					step_window();
					if (window_at_end())
						rest_idle();
				end
			end
			ST_PINCH_OPEN: begin
				bump_dwell();
				if (dwell >= step_lim) begin
					dwell = '0;
					reopen_step();
				end
			end
			ST_PINCH_HOLD: begin
				bump_dwell();
				if (dwell >= hold_lim)
					rest_idle();
			end
			default: rest_idle();
		endcase
		lvl = (opening > NUM_STEPS) ? 4'(NUM_STEPS) : opening;
		open_mask = (11'd1 << lvl) - 11'd1;
		r.bar_leds = ~open_mask[WLC_BAR_W-1:0];
		r.window_level = lvl;
		r.motor_up = (wl_state == ST_MANUAL || wl_state == ST_AUTO) && !going_down;
		r.motor_down = ((wl_state == ST_MANUAL || wl_state == ST_AUTO) && going_down) ||
			wl_state == ST_PINCH_OPEN;
		r.pinch_lockout = wl_state == ST_PINCH_OPEN || wl_state == ST_PINCH_HOLD;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v,
				act_v);
			mismatches++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.up_button = 1'b0;
		tick_ch.down_button = 1'b0;
		tick_ch.pinch_sensor = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#4000000;
		$display("** window_lifter_controller: FAILED **");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
			tick_ch.up_button <= 1'b0;
			tick_ch.down_button <= 1'b0;
			tick_ch.pinch_sensor <= 1'b0;
			src_gap <= 0;
		end else if (!tick_ch.valid || tick_ch.ready) begin
			if (src_gap != 0) begin
				tick_ch.valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (tick_q.size() != 0 && $urandom_range(99) < src_idle_pct) begin
				tick_ch.valid <= 1'b0;
				src_gap <= $urandom_range(14);
			end else if (tick_q.size() != 0) begin
				next_tick = tick_q.pop_front();
				tick_ch.valid <= 1'b1;
				tick_ch.up_button <= next_tick.up;
				tick_ch.down_button <= next_tick.dn;
				tick_ch.pinch_sensor <= next_tick.pin;
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= '0;
			cfg_ch.data <= '0;
		end else if (!cfg_ch.valid || cfg_ch.ready) begin
			if (reg_write_q.size() != 0) begin
				next_write = reg_write_q.pop_front();
				cfg_ch.valid <= 1'b1;
				cfg_ch.index <= next_write.idx;
				cfg_ch.data <= next_write.data;
			end else begin
				cfg_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_gap <= 0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done != holds_req) begin
			res_ch.ready <= 1'b0;
			hold_left <= LONG_HOLD - 1;
			holds_done <= holds_done + 1;
		end else if (sink_gap != 0) begin
			res_ch.ready <= 1'b0;
			sink_gap <= sink_gap - 1;
		end else if ($urandom_range(99) < sink_idle_pct) begin
			res_ch.ready <= 1'b0;
			sink_gap <= $urandom_range(14);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (window_q.size() == 0) begin
					$display("%0t: result transaction with no expected value, actual %0h",
						$time, {res_ch.bar_leds, res_ch.window_level, res_ch.motor_up,
						res_ch.motor_down, res_ch.pinch_lockout});
					mismatches++;
				end else begin
					want = window_q.pop_front();
					check_field("bar_leds", 16'(want.bar_leds), 16'(res_ch.bar_leds));
					check_field("window_level", 16'(want.window_level),
						16'(res_ch.window_level));
					check_field("motor_up", 16'(want.motor_up), 16'(res_ch.motor_up));
					check_field("motor_down", 16'(want.motor_down), 16'(res_ch.motor_down));
					check_field("pinch_lockout", 16'(want.pinch_lockout),
						16'(res_ch.pinch_lockout));
				end
			end
			if (tick_ch.valid && tick_ch.ready)
				window_q.push_back(predict_window(tick_ch.up_button, tick_ch.down_button,
					tick_ch.pinch_sensor));
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_DEBOUNCE: deb_lim = cfg_ch.data[WLC_DEB_W-1:0];
					REG_ONESHOT: os_lim = cfg_ch.data;
					REG_STEP: step_lim = cfg_ch.data;
					REG_PINCH_HOLD: hold_lim = cfg_ch.data;
					default: ;
				endcase
			end
		end
	end

	task automatic push_tick(input logic up, input logic dn, input logic pin);
		tick_q.push_back('{up: up, dn: dn, pin: pin});
		ticks_queued++;
	endtask

	task automatic push_write(input logic [WLC_CFG_IDX_W-1:0] idx,
		input logic [WLC_CFG_DATA_W-1:0] data);
		reg_write_q.push_back('{idx: idx, data: data});
	endtask

	task automatic set_regs(input logic [15:0] deb, input logic [15:0] os,
		input logic [15:0] step, input logic [15:0] hold);
		push_write(REG_DEBOUNCE, deb);
		push_write(REG_ONESHOT, os);
		push_write(REG_STEP, step);
		push_write(REG_PINCH_HOLD, hold);
		g_deb = (deb[WLC_DEB_W-1:0] == 0) ? 1 : int'(deb[WLC_DEB_W-1:0]);
		g_os = (os == 0) ? 1 : int'(os);
		g_step = (step == 0) ? 1 : int'(step);
		g_hold = (hold == 0) ? 1 : int'(hold);
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || tick_ch.valid || window_q.size() != 0 ||
			reg_write_q.size() != 0 || cfg_ch.valid)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	function automatic logic rare_pinch();
		return $urandom_range(24) == 0;
	endfunction

	// Mostly full presses sized to the current timing, so that travel, decisions
	// and pinch reopening are reached; the rest is random button noise.
	task automatic gen_random(input int count);
		int stop_at;
		int hold_len;
		int rest_len;
		logic up;
		logic dn;
		stop_at = ticks_queued + count;
		while (ticks_queued < stop_at) begin
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(1, 5))
					push_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1)));
			end else begin
				case ($urandom_range(3))
					0: hold_len = $urandom_range(1, g_deb);
					1: hold_len = g_deb + $urandom_range(0, g_os);
					2: hold_len = g_deb + g_os + $urandom_range(0, g_step * (NUM_STEPS + 1));
					default: hold_len = $urandom_range(1, g_deb + g_os + 4 * g_step);
				endcase
				dn = $urandom_range(2) == 0;
				up = !dn || $urandom_range(3) == 0;
				for (int i = 0; i < hold_len && ticks_queued < stop_at; i++)
					push_tick(up || $urandom_range(11) == 0, dn || $urandom_range(11) == 0,
						rare_pinch());
				rest_len = $urandom_range(1, g_step * (NUM_STEPS + 2) + g_hold + 2);
				for (int i = 0; i < rest_len && ticks_queued < stop_at; i++)
					push_tick(1'b0, 1'b0, rare_pinch());
			end
		end
	endtask

	initial begin
		logic [1:0] combo;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		holds_req = 0;
		mismatches = 0;
		ticks_queued = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// Reset timing: presses released before the debounce count completes.
		src_idle_pct <= 20;
		sink_idle_pct <= 20;
		repeat (6) begin
			combo = 2'($urandom_range(1, 3));
			repeat ($urandom_range(1, 9))
				push_tick(combo[0], combo[1], 1'($urandom_range(1)));
			repeat ($urandom_range(1, 3))
				push_tick(1'b0, 1'b0, 1'($urandom_range(1)));
		end
		drain();

		src_idle_pct <= 0;
		sink_idle_pct <= 0;
		set_regs(16'd1, 16'd2, 16'd1, 16'd2);
		drain();
		foreach (OPENING_SCRIPT[i])
			push_tick(OPENING_SCRIPT[i][2], OPENING_SCRIPT[i][1], OPENING_SCRIPT[i][0]);
		drain();

		set_regs(16'd0, 16'd0, 16'd0, 16'd0);
		drain();
		src_idle_pct <= 25;
		sink_idle_pct <= 25;
		gen_random(120);
		drain();

		set_regs(16'($urandom_range(1, 3)), 16'($urandom_range(1, 5)),
			16'($urandom_range(1, 3)), 16'($urandom_range(1, 8)));
		drain();
		src_idle_pct <= 10;
		sink_idle_pct <= 40;
		holds_req <= holds_req + 1;
		gen_random(250);
		drain();

		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_write(REG_UNUSED, 16'($urandom_range(16'hFFFF)));
		drain();
		src_idle_pct <= 30;
		sink_idle_pct <= 30;
		gen_random(40);
		drain();

		set_regs(16'($urandom_range(2, 6)), 16'($urandom_range(2, 10)),
			16'($urandom_range(2, 6)), 16'($urandom_range(5, 30)));
		drain();
		src_idle_pct <= 15;
		sink_idle_pct <= 15;
		holds_req <= holds_req + 1;
		gen_random(230);
		drain();

		set_regs(16'($urandom_range(1, 3)), 16'($urandom_range(1, 5)),
			16'($urandom_range(1, 3)), 16'($urandom_range(1, 8)));
		src_idle_pct <= 0;
		sink_idle_pct <= 0;
		drain();
		gen_random(230);
		drain();
		repeat (10) @(negedge clk);

		if (mismatches == 0 && window_q.size() == 0)
			$display("** window_lifter_controller: PASSED **");
		else
			$display("** window_lifter_controller: FAILED **");
		$finish;
	end

endmodule

[sim.f]
rtl/core/wlc_pkg.sv
rtl/core/wlc_if.sv
rtl/core/wlc_fsm.sv
rtl/core/window_lifter_controller.sv
verif/window_lifter_controller_tb.sv
